[hw/rtl/rpcd_pkg.sv]
`default_nettype none
package rpcd_pkg;

    localparam int unsigned POS_W = 16;
    localparam int unsigned RNG_W = 16;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned CRD_W = 33;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SEP   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_ANG = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ANG_STEP  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LO  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_HI  = 3'd5;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos1;
        logic [POS_W-1:0] pos2;
        logic [RNG_W-1:0] dist1;
        logic [RNG_W-1:0] dist2;
    } t_job;

    typedef struct packed {
        logic [15:0] start_angle;
        logic [15:0] angle_step;
    } t_geom;

    function automatic logic signed [CRD_W-1:0] atan_entry(input logic [3:0] idx);
        logic signed [CRD_W-1:0] v;
        unique case (idx)
            4'd0:  v = 33'sd536870912;
            4'd1:  v = 33'sd316933406;
            4'd2:  v = 33'sd167458907;
            4'd3:  v = 33'sd85004756;
            4'd4:  v = 33'sd42667331;
            4'd5:  v = 33'sd21354465;
            4'd6:  v = 33'sd10679838;
            4'd7:  v = 33'sd5340245;
            4'd8:  v = 33'sd2670163;
            4'd9:  v = 33'sd1335087;
            4'd10: v = 33'sd667544;
            4'd11: v = 33'sd333772;
            4'd12: v = 33'sd166886;
            4'd13: v = 33'sd83443;
            4'd14: v = 33'sd41722;
            default: v = 33'sd20861;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/rpcd_front.sv]
`default_nettype none
module rpcd_front
    import rpcd_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 2048
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [15:0]      i_intensity,
    input  wire logic [15:0]      i_range,
    input  wire logic             i_finite,
    input  wire logic             i_last,
    input  wire logic [15:0]      i_threshold,
    input  wire logic [10:0]      i_min_sep,
    input  wire logic [15:0]      i_range_lo,
    input  wire logic [15:0]      i_range_hi,
    output logic                  o_push,
    output t_job                  o_job
);

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned PW    = $clog2(MAX_SAMPLES);
    localparam int unsigned DW    = (PW > 11) ? PW : 11;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ff, n_ff, r_sf, n_sf, r_fok, n_fok, r_sok, n_sok;
    logic [PW-1:0]    r_p1, n_p1, r_p2, n_p2;
    logic [15:0]      r_d1, n_d1, r_d2, n_d2;
    logic [PW-1:0]    idx;
    logic             in_win, ok;
    logic [DW-1:0]    gap;

    assign idx    = r_count[PW-1:0];
    assign in_win = r_count < CNT_W'(MAX_SAMPLES);
    assign ok     = i_finite && (i_range >= i_range_lo) && (i_range <= i_range_hi);
    assign gap    = DW'(idx) - DW'(r_p1);

    always_comb begin
        n_count = r_count;
        n_ff = r_ff; n_sf = r_sf; n_fok = r_fok; n_sok = r_sok;
        n_p1 = r_p1; n_p2 = r_p2; n_d1 = r_d1; n_d2 = r_d2;
        if (in_win) begin
            n_count = r_count + CNT_W'(1);
            if (i_intensity >= i_threshold) begin
                if (!r_ff) begin
                    n_ff = 1'b1; n_p1 = idx; n_d1 = i_range; n_fok = ok;
                end else if (!r_sf && (gap >= DW'(i_min_sep))) begin
                    n_sf = 1'b1; n_p2 = idx; n_d2 = i_range; n_sok = ok;
                end
            end
        end
    end

    assign o_push      = i_accept && i_last;
    assign o_job.found = n_ff && n_sf && n_fok && n_sok;
    assign o_job.pos1  = POS_W'(n_p1);
    assign o_job.pos2  = POS_W'(n_p2);
    assign o_job.dist1 = n_d1;
    assign o_job.dist2 = n_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count <= '0;
            r_ff <= 1'b0; r_sf <= 1'b0; r_fok <= 1'b0; r_sok <= 1'b0;
            r_p1 <= '0; r_p2 <= '0; r_d1 <= '0; r_d2 <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_ff <= n_ff; r_sf <= n_sf; r_fok <= n_fok; r_sok <= n_sok;
            r_p1 <= n_p1; r_p2 <= n_p2; r_d1 <= n_d1; r_d2 <= n_d2;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rpcd_queue.sv]
`default_nettype none
module rpcd_queue
    import rpcd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rpcd_back.sv]
`default_nettype none
module rpcd_back
    import rpcd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  t_job               i_job,
    input  t_geom              i_geom,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_found,
    output logic signed [16:0] o_cx,
    output logic signed [16:0] o_cy
);

    typedef enum logic [2:0] {S_IDLE, S_MULA, S_ANG, S_ROT, S_TRIG, S_MUL, S_ACC, S_OUT}
        t_state;

    t_state                  r_state;
    t_job                    r_job;
    logic                    r_leg;
    logic [31:0]             r_prod;
    logic [1:0]              r_quad;
    logic [3:0]              r_it;
    logic signed [CRD_W-1:0] r_x, r_y, r_z;
    logic signed [16:0]      r_c, r_s;
    logic signed [33:0]      r_pc, r_ps;
    logic signed [35:0]      r_ax, r_ay;
    logic [15:0]             ang;
    logic signed [CRD_W-1:0] dx, dy, at;
    logic signed [16:0]      cq, sq;
    logic [15:0]             leg_dist;
    logic signed [35:0]      sx, sy;

    function automatic logic signed [16:0] to_q15(input logic signed [CRD_W-1:0] v);
        logic signed [CRD_W:0] t;
        t = ($signed({v[CRD_W-1], v}) + 34'sd16384) >>> 15;
        if (t > 34'sd32767) return 17'sd32767;
        if (t < -34'sd32768) return -17'sd32768;
        return 17'(t);
    endfunction

    function automatic logic signed [16:0] to_mid(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + 36'sd32768) >>> 16;
        if (t > 36'sd65535) return 17'sd65535;
        if (t < -36'sd65535) return -17'sd65535;
        return 17'(t);
    endfunction

    assign ang  = i_geom.start_angle + r_prod[15:0];
    assign dx   = r_y >>> r_it;
    assign dy   = r_x >>> r_it;
    assign at   = atan_entry(r_it);
    assign cq   = to_q15(r_x);
    assign sq   = to_q15(r_y);
    assign leg_dist = r_leg ? r_job.dist2 : r_job.dist1;
    assign sx   = r_ax + 36'(r_pc);
    assign sy   = r_ay + 36'(r_ps);
    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        r_leg <= 1'b0;
                        r_ax  <= '0;
                        r_ay  <= '0;
                        if (i_job.found) begin
                            r_state <= S_MULA;
                        end else begin
                            o_found <= 1'b0; o_cx <= '0; o_cy <= '0;
                            o_valid <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_MULA: begin
                    r_prod  <= (r_leg ? r_job.pos2 : r_job.pos1) * i_geom.angle_step;
                    r_state <= S_ANG;
                end
                S_ANG: begin
                    r_quad  <= ang[15:14];
                    r_x     <= 33'sd652032874;
                    r_y     <= '0;
                    r_z     <= $signed({3'b000, ang[13:0], 16'h0000});
                    r_it    <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (!r_z[CRD_W-1]) begin
                        r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + at;
                    end
                    r_it <= r_it + 4'd1;
                    if (r_it == 4'(CORDIC_STEPS - 1)) r_state <= S_TRIG;
                end
                S_TRIG: begin
                    unique case (r_quad)
                        2'd0: begin r_c <= cq;  r_s <= sq;  end
                        2'd1: begin r_c <= -sq; r_s <= cq;  end
                        2'd2: begin r_c <= -cq; r_s <= -sq; end
                        default: begin r_c <= sq; r_s <= -cq; end
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pc    <= $signed({1'b0, leg_dist}) * r_c;
                    r_ps    <= $signed({1'b0, leg_dist}) * r_s;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_ax <= sx;
                    r_ay <= sy;
                    if (!r_leg) begin
                        r_leg   <= 1'b1;
                        r_state <= S_MULA;
                    end else begin
                        o_found <= 1'b1;
                        o_cx    <= to_mid(sx);
                        o_cy    <= to_mid(sy);
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/reflector_pair_center_detector_core.sv]
// Samples are taken one per cycle whenever the job queue has room; the queue holds two scans.
// A result follows the last sample of its scan through the job queue and the back end: the shared
// CORDIC runs 16 rotation steps per leg, two legs one after the other, plus set-up and scaling.
// Scans that end with fewer than two valid legs skip the CORDIC: their result is registered from the queue.
// Synchronous active-low reset restores register defaults and clears scan state and queue.
`default_nettype none
module reflector_pair_center_detector_core
    import rpcd_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [39:0]           s_axis_tdata,  // sample_intensity, sample_range, range_finite
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [39:0]                m_axis_tdata,  // center_x, center_y
    output logic                       m_axis_tuser,  // legs_found
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [15:0]        r_thr, r_start, r_step, r_lo, r_hi;
    logic [10:0]        r_sep;
    logic               accept, push, full, empty, pop, found;
    t_job               fjob, qjob;
    t_geom              geom;
    logic signed [16:0] cx, cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd8000; r_sep <= 11'd10; r_start <= 16'h8000;
            r_step <= 16'd91; r_lo <= 16'd0; r_hi <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_THRESHOLD: r_thr   <= i_cfg_wdata;
                REG_MIN_SEP:   r_sep   <= i_cfg_wdata[10:0];
                REG_START_ANG: r_start <= i_cfg_wdata;
                REG_ANG_STEP:  r_step  <= i_cfg_wdata;
                REG_RANGE_LO:  r_lo    <= i_cfg_wdata;
                REG_RANGE_HI:  r_hi    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign geom.start_angle = r_start;
    assign geom.angle_step  = r_step;

    rpcd_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_intensity(s_axis_tdata[15:0]), .i_range(s_axis_tdata[31:16]),
        .i_finite(s_axis_tdata[32]), .i_last(s_axis_tlast),
        .i_threshold(r_thr), .i_min_sep(r_sep), .i_range_lo(r_lo), .i_range_hi(r_hi),
        .o_push(push), .o_job(fjob)
    );

    rpcd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(fjob),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_job(qjob)
    );

    rpcd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(qjob), .i_geom(geom),
        .o_pop(pop), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_found(found), .o_cx(cx), .o_cy(cy)
    );

    assign m_axis_tuser = found;
    assign m_axis_tdata = {6'd0, cy, cx};

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
    import rpcd_pkg::*;

    localparam int unsigned SCAN_DEPTH = 2048;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam longint ATAN_LUT [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    typedef struct {
        bit                 found;
        logic signed [16:0] x;
        logic signed [16:0] y;
    } t_centre;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [39:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    reflector_pair_center_detector_core #(.MAX_SAMPLES(SCAN_DEPTH)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Shadow registers and scan state of the detector.
    bit [15:0] thr_reg, start_reg, step_reg, lo_reg, hi_reg;
    bit [10:0] sep_reg;
    int        scan_idx;
    bit        leg1_seen, leg2_seen, leg1_ok, leg2_ok;
    int        leg1_pos, leg2_pos;
    bit [15:0] leg1_dist, leg2_dist;

    t_centre   centre_q[$];
    int        mismatch_count;
    int        quiet_cycles;
    int        hold_request;
    int        hold_left;
    bit        steady;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint to_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic void sin_cos(input bit [15:0] ang, output longint c, output longint s);
        longint x, y, z, dx, dy, cc, ss;
        x = 652032874;
        y = 0;
        z = longint'(ang[13:0]) << 16;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_LUT[i];
            end else begin
                x += dx; y -= dy; z += ATAN_LUT[i];
            end
        end
        cc = to_q15(x);
        ss = to_q15(y);
        case (ang[15:14])
            2'd0: begin c = cc;  s = ss;  end
            2'd1: begin c = -ss; s = cc;  end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic longint halve_sum(input longint sum);
        longint r;
        r = (sum + 32768) >>> 16;
        if (r > 65535) r = 65535;
        if (r < -65535) r = -65535;
        return r;
    endfunction

    function automatic void clear_scan();
        scan_idx = 0;
        leg1_seen = 0; leg2_seen = 0; leg1_ok = 0; leg2_ok = 0;
        leg1_pos = 0; leg2_pos = 0; leg1_dist = 0; leg2_dist = 0;
    endfunction

    function automatic void track_sample(input bit [15:0] inten, input bit [15:0] rng,
                                         input bit fin, input bit last);
        bit        ok;
        bit [15:0] a1, a2;
        longint    c1, s1, c2, s2;
        t_centre   res;
        if (scan_idx < SCAN_DEPTH) begin
            ok = fin && rng >= lo_reg && rng <= hi_reg;
            if (inten >= thr_reg) begin
                if (!leg1_seen) begin
                    leg1_seen = 1; leg1_pos = scan_idx; leg1_dist = rng; leg1_ok = ok;
                end else if (!leg2_seen && scan_idx - leg1_pos >= sep_reg) begin
                    leg2_seen = 1; leg2_pos = scan_idx; leg2_dist = rng; leg2_ok = ok;
                end
            end
            scan_idx++;
        end
        if (last) begin
            res = '{found: 0, x: 0, y: 0};
            if (leg1_seen && leg2_seen && leg1_ok && leg2_ok) begin
                a1 = start_reg + 16'(leg1_pos * step_reg);
                a2 = start_reg + 16'(leg2_pos * step_reg);
                sin_cos(a1, c1, s1);
                sin_cos(a2, c2, s2);
                res.found = 1;
                res.x = 17'(halve_sum(longint'(leg1_dist) * c1 + longint'(leg2_dist) * c2));
                res.y = 17'(halve_sum(longint'(leg1_dist) * s1 + longint'(leg2_dist) * s2));
            end
            centre_q.push_back(res);
            clear_scan();
        end
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        t_centre want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (centre_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result tuser=%0b tdata=%h", $time,
                         m_axis_tuser, m_axis_tdata);
            end else begin
                want = centre_q.pop_front();
                if (m_axis_tuser !== want.found || m_axis_tdata[16:0] !== want.x ||
                    m_axis_tdata[33:17] !== want.y) begin
                    mismatch_count++;
                    $display("%0t: expected found=%0b x=%0d y=%0d, got found=%0b x=%0d y=%0d",
                             $time, want.found, want.x, want.y, m_axis_tuser,
                             $signed(m_axis_tdata[16:0]), $signed(m_axis_tdata[33:17]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input bit [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_reg = val;
            REG_MIN_SEP:   sep_reg = val[10:0];
            REG_START_ANG: start_reg = val;
            REG_ANG_STEP:  step_reg = val;
            REG_RANGE_LO:  lo_reg = val;
            REG_RANGE_HI:  hi_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_all(input bit [15:0] thr, input bit [15:0] sep, input bit [15:0] start,
                           input bit [15:0] step, input bit [15:0] lo, input bit [15:0] hi);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MIN_SEP, sep);
        write_reg(REG_START_ANG, start);
        write_reg(REG_ANG_STEP, step);
        write_reg(REG_RANGE_LO, lo);
        write_reg(REG_RANGE_HI, hi);
    endtask

    task automatic send_sample(input bit [15:0] inten, input bit [15:0] rng,
                               input bit fin, input bit last);
        if (!steady && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, fin, rng, inten};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        track_sample(inten, rng, fin, last);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (centre_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic bit [15:0] good_range();
        if (lo_reg <= hi_reg && $urandom_range(9) != 0) return $urandom_range(hi_reg, lo_reg);
        return $urandom;
    endfunction

    function automatic bit [15:0] dim_value();
        if (thr_reg == 0) return 0;
        return $urandom_range(thr_reg - 1, 0);
    endfunction

    // Mostly a planted pair of legs on a dim background; otherwise random noise.
    task automatic send_scan(input int len);
        int p1, p2;
        bit planted;
        bit [15:0] inten;
        planted = $urandom_range(99) < 70;
        p1 = $urandom_range(len - 1, 0);
        p2 = p1 + sep_reg + $urandom_range(3, 0);
        for (int k = 0; k < len; k++) begin
            if (planted) inten = (k == p1 || k == p2 || $urandom_range(19) == 0) ?
                                 16'($urandom_range(65535, thr_reg)) : dim_value();
            else inten = $urandom;
            send_sample(inten, good_range(), $urandom_range(9) != 0, k == len - 1);
        end
    endtask

    task automatic test_directed();
        send_sample(16'd8000, 16'd1000, 1, 0);
        for (int k = 1; k < 10; k++) send_sample(16'd7999, 16'd5, 1, 0);
        send_sample(16'hFFFF, 16'hFFFF, 1, 0);
        send_sample(16'hFFFF, 16'd3, 1, 1);
        send_sample(16'hFFFF, 16'd500, 1, 1);
        send_sample(16'hFFFF, 16'd500, 0, 0);
        for (int k = 1; k < 11; k++) send_sample(16'hFFFF, 16'd0, 1, k == 10);
        send_sample(16'd0, 16'd0, 0, 1);
        drain();
        set_all(16'd0, 16'd0, 16'h4000, 16'hFFFF, 16'd200, 16'd100);
        send_sample(16'd0, 16'd150, 1, 0);
        send_sample(16'd0, 16'd150, 1, 1);
        drain();
        write_reg(REG_RANGE_LO, 16'd0);
        write_reg(REG_RANGE_HI, 16'hFFFF);
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'hFFFF);
        send_sample(16'd0, 16'hFFFF, 1, 0);
        send_sample(16'd0, 16'hFFFF, 1, 1);
        drain();
    endtask

    task automatic test_overlong_scan();
        set_all(16'd30000, 16'd2047, 16'h7FFF, 16'd32, 16'd0, 16'hFFFF);
        steady = 1;
        for (int k = 0; k < SCAN_DEPTH + 40; k++)
            send_sample((k == 0 || k == SCAN_DEPTH - 1 || k > SCAN_DEPTH) ? 16'hFFFF : 16'd100,
                        16'(k * 31), 1, k == SCAN_DEPTH + 39);
        steady = 0;
        drain();
    endtask

    task automatic test_receiver_hold();
        set_all(16'd8000, 16'd2, 16'h8000, 16'd91, 16'd0, 16'hFFFF);
        hold_request = 400;
        for (int n = 0; n < 20; n++) send_scan(4);
        drain();
    endtask

    task automatic test_random_scans();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: set_all(16'hFFFF, 16'd0, 16'h8000, 16'd0, 16'd0, 16'hFFFF);
                1: set_all(16'd0, 16'd2047, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_all($urandom, $urandom_range(12, 0), $urandom, $urandom,
                                 $urandom_range(20000, 0), $urandom_range(65535, 15000));
            endcase
            steady = (phase == 4);
            repeat (15) send_scan($urandom_range(($urandom_range(9) == 0) ? 60 : 14, 1));
            steady = 0;
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        hold_request = 0;
        hold_left = 0;
        steady = 0;
        thr_reg = 16'd8000; sep_reg = 11'd10; start_reg = 16'h8000;
        step_reg = 16'd91; lo_reg = 16'd0; hi_reg = 16'hFFFF;
        clear_scan();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_overlong_scan();
        test_receiver_hold();
        test_random_scans();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rpcd_pkg.sv
hw/rtl/rpcd_front.sv
hw/rtl/rpcd_queue.sv
hw/rtl/rpcd_back.sv
hw/rtl/reflector_pair_center_detector_core.sv
tb/sv/testbench.sv
